// ===== sv/pwmpp_pkg.sv =====
// Package for the PWM prescaler and period planner.
// Holds field widths, command and register codes, divider tables and the divider request and response types.
// Depends on nothing; every other file of the block imports it.
package pwmpp_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned FREQ_W    = 30;
  localparam int unsigned SRC_W     = 28;
  localparam int unsigned MULT_W    = 13;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned FDES_W    = 27;
  localparam int unsigned PROD_W    = 11;
  localparam int unsigned GRID_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned DIV_DEND_W = 34;
  localparam int unsigned DIV_DSOR_W = 31;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FAST   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GRID   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MULT    = 1'b1;

  localparam logic [SRC_W-1:0]    SOURCE_CLOCK_RESET = 28'd100000000;
  localparam logic [MULT_W-1:0]   GRID_MULT_RESET    = 13'd512;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD       = 16'd1000;
  localparam logic [PERIOD_W-1:0] FALLBACK_PERIOD    = 16'd60000;
  localparam logic [GRID_W-1:0]   GRID_LOW           = 11'd560;
  localparam logic [GRID_W-1:0]   GRID_HIGH          = 11'd1280;

  localparam logic [DIV_CNT_W-1:0] TICK_STEPS  = 6'd28;
  localparam logic [DIV_CNT_W-1:0] COUNT_STEPS = 6'd29;
  localparam logic [DIV_CNT_W-1:0] FAST_STEPS  = 6'd34;

  typedef struct packed {
    logic                  start;
    logic [DIV_DEND_W-1:0] dividend;
    logic [DIV_DSOR_W-1:0] divisor;
    logic [DIV_CNT_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_DEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [3:0] hs_div_val(input logic [SEL_W-1:0] sel);
    logic [3:0] val;
    unique case (sel)
      3'd0:    val = 4'd1;
      3'd1:    val = 4'd2;
      3'd2:    val = 4'd4;
      3'd3:    val = 4'd6;
      3'd4:    val = 4'd8;
      3'd5:    val = 4'd10;
      3'd6:    val = 4'd12;
      default: val = 4'd14;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/pwmpp_in_if.sv =====
// Input channel of the PWM planner: valid, ready, command and requested frequency.
// Depends on pwmpp_pkg for the field widths.
interface pwmpp_in_if import pwmpp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [FREQ_W-1:0] freq_sixteenths;

  modport source(output valid, output command, output freq_sixteenths, input ready);
  modport sink(input valid, input command, input freq_sixteenths, output ready);
endinterface

// ===== sv/pwmpp_out_if.sv =====
// Result channel of the PWM planner: valid, ready and the planned divider and period settings.
// Depends on pwmpp_pkg for the field widths.
interface pwmpp_out_if import pwmpp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SEL_W-1:0]    clock_div_index;
  logic [SEL_W-1:0]    hs_div_index;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] compare;
  logic                output_enabled;
  logic                prescaler_changed;
  logic                updated;

  modport source(output valid, output clock_div_index, output hs_div_index, output period,
                 output compare, output output_enabled, output prescaler_changed,
                 output updated, input ready);
  modport sink(input valid, input clock_div_index, input hs_div_index, input period,
               input compare, input output_enabled, input prescaler_changed,
               input updated, output ready);
endinterface

// ===== sv/pwmpp_div.sv =====
// Shared restoring divider of the PWM planner, one quotient bit per cycle.
// The dividend arrives left aligned; steps sets how many of its upper bits are divided.
// Depends on pwmpp_pkg for the request and response types.
module pwmpp_div import pwmpp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  done_q;
  logic [DIV_DEND_W-1:0] quo_q;
  logic [DIV_DSOR_W-1:0] rem_q;
  logic [DIV_DSOR_W-1:0] dsor_q;
  logic [DIV_DSOR_W:0]   rem_shift;
  logic [DIV_DSOR_W+1:0] diff;

  assign rem_shift = {rem_q, quo_q[DIV_DEND_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dsor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= req_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q  <= req_i.dividend;
      rem_q  <= '0;
      dsor_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_DEND_W-2:0], ~diff[DIV_DSOR_W+1]};
      rem_q <= diff[DIV_DSOR_W+1] ? rem_shift[DIV_DSOR_W-1:0] : diff[DIV_DSOR_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sv/pwm_prescaler_period_planner_core.sv =====
// PWM prescaler and period planner. Takes one command transaction at a time on in_i and
// returns one result transaction on out_o with the divider pair, period and compare value.
//
// Commands: search scans every clock and high-speed divider pair for the smallest product
// whose rounded count fits the 16-bit time base; fast set keeps the dividers and computes the
// period from the requested frequency; grid set clamps the frequency to 35..80 Hz, scales it
// by grid_multiplier and then does a fast set. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_wdata_i only while the block is idle; the block itself does not enforce it.
//
// A search runs a tick division and, where the tick is non-zero, a count division for each divider
// pair; a fast set runs a tick division and, where tick and frequency are non-zero, a period division,
// and a grid set first clamps and scales the frequency. Their time is set by the single shared
// bit-serial divider, which produces one quotient bit per cycle. The block takes one transaction at a
// time: in_i.ready is high only while it is idle. A finished result sits in the output register, so the
// next command can be accepted while the receiver stalls; its result then waits until out_o is free.
// Reset clears the dividers to divide by one, sets the period to 1000, stops the output
// and loads the configuration reset values.
// Depends on pwmpp_pkg, pwmpp_in_if, pwmpp_out_if and pwmpp_div.
module pwm_prescaler_period_planner_core import pwmpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pwmpp_in_if.sink             in_i,
  pwmpp_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SRC_W-1:0]     cfg_wdata_i
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_GRID      = 10'b00_0000_0010,
    ST_TICK_GO   = 10'b00_0000_0100,
    ST_TICK_WAIT = 10'b00_0000_1000,
    ST_CNT_GO    = 10'b00_0001_0000,
    ST_CNT_WAIT  = 10'b00_0010_0000,
    ST_NEXT      = 10'b00_0100_0000,
    ST_FAST_GO   = 10'b00_1000_0000,
    ST_FAST_WAIT = 10'b01_0000_0000,
    ST_DONE      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [SRC_W-1:0]    src_q;
  logic [MULT_W-1:0]   mult_q;
  logic [SEL_W-1:0]    clk_sel_q, clk_sel_d;
  logic [SEL_W-1:0]    hs_sel_q, hs_sel_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                running_q, running_d;
  logic                out_valid_q, out_valid_d;

  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [FREQ_W-1:0]   f_q, f_d;
  logic [FDES_W-1:0]   fdes_q, fdes_d;
  logic [FREQ_W-1:0]   fv_q, fv_d;
  logic [SRC_W-1:0]    tick_q, tick_d;
  logic [SEL_W-1:0]    i_q, i_d;
  logic [SEL_W-1:0]    j_q, j_d;
  logic                found_q, found_d;
  logic [PROD_W-1:0]   min_prod_q, min_prod_d;
  logic [SEL_W-1:0]    best_c_q, best_c_d;
  logic [SEL_W-1:0]    best_h_q, best_h_d;
  logic [PERIOD_W-1:0] best_p_q, best_p_d;
  logic                changed_q, changed_d;
  logic                upd_q, upd_d;

  logic [SEL_W-1:0]    o_cdiv_q, o_hdiv_q;
  logic [PERIOD_W-1:0] o_period_q, o_compare_q;
  logic                o_enabled_q, o_changed_q, o_updated_q;
  logic                out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [FDES_W-1:0]     fdes_in;
  logic [GRID_W-1:0]     grid_clamp;
  logic [PROD_W-1:0]     prod;
  logic [DIV_DEND_W-1:0] quot;
  logic                  quot_low;
  logic                  quot_high;
  logic [PERIOD_W-1:0]   quot_m1;
  logic [PERIOD_W-1:0]   fast_period;

  pwmpp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign fdes_in = FDES_W'((31'(in_i.freq_sixteenths) + 31'd8) >> 4);

  always_comb begin
    if (f_q < FREQ_W'(GRID_LOW)) begin
      grid_clamp = GRID_LOW;
    end else if (f_q > FREQ_W'(GRID_HIGH)) begin
      grid_clamp = GRID_HIGH;
    end else begin
      grid_clamp = f_q[GRID_W-1:0];
    end
  end

  assign prod      = PROD_W'(hs_div_val(j_q)) << i_q;
  assign quot      = div_rsp.quotient;
  assign quot_low  = (quot[DIV_DEND_W-1:1] == '0);
  assign quot_high = (quot > DIV_DEND_W'(34'd65536));
  assign quot_m1   = PERIOD_W'(quot[PERIOD_W:0] - 17'd1);

  always_comb begin
    if (quot_low) begin
      fast_period = PERIOD_W'(1);
    end else if (quot_high) begin
      fast_period = '1;
    end else begin
      fast_period = quot_m1;
    end
  end

  always_comb begin
    state_d     = state_q;
    clk_sel_d   = clk_sel_q;
    hs_sel_d    = hs_sel_q;
    period_d    = period_q;
    running_d   = running_q;
    cmd_d       = cmd_q;
    f_d         = f_q;
    fdes_d      = fdes_q;
    fv_d        = fv_q;
    tick_d      = tick_q;
    i_d         = i_q;
    j_d         = j_q;
    found_d     = found_q;
    min_prod_d  = min_prod_q;
    best_c_d    = best_c_q;
    best_h_d    = best_h_q;
    best_p_d    = best_p_q;
    changed_d   = changed_q;
    upd_d       = upd_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_o.ready;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d     = in_i.command;
          f_d       = in_i.freq_sixteenths;
          fdes_d    = fdes_in;
          fv_d      = in_i.freq_sixteenths;
          i_d       = clk_sel_q;
          j_d       = hs_sel_q;
          found_d   = 1'b0;
          changed_d = 1'b0;
          upd_d     = 1'b0;
          unique case (in_i.command)
            CMD_SEARCH: begin
              i_d     = '0;
              j_d     = '0;
              state_d = (fdes_in == '0) ? ST_DONE : ST_TICK_GO;
            end
            CMD_FAST: state_d = ST_TICK_GO;
            CMD_GRID: state_d = ST_GRID;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_GRID: begin
        fv_d    = FREQ_W'(grid_clamp * mult_q);
        state_d = ST_TICK_GO;
      end
      ST_TICK_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {src_q >> i_q, 6'b00_0000};
        div_req.divisor  = DIV_DSOR_W'(hs_div_val(j_q));
        div_req.steps    = TICK_STEPS;
        state_d          = ST_TICK_WAIT;
      end
      ST_TICK_WAIT: begin
        if (div_rsp.done) begin
          tick_d = quot[SRC_W-1:0];
          if (cmd_q == CMD_SEARCH) begin
            state_d = (quot[SRC_W-1:0] == '0) ? ST_NEXT : ST_CNT_GO;
          end else if (quot[SRC_W-1:0] == '0) begin
            state_d = ST_DONE;
          end else if (fv_q == '0) begin
            running_d = 1'b0;
            upd_d     = 1'b1;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_FAST_GO;
          end
        end
      end
      ST_CNT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {29'(tick_q) + 29'(fdes_q >> 1), 5'b0_0000};
        div_req.divisor  = DIV_DSOR_W'(fdes_q);
        div_req.steps    = COUNT_STEPS;
        state_d          = ST_CNT_WAIT;
      end
      ST_CNT_WAIT: begin
        if (div_rsp.done) begin
          if (!quot_low && !quot_high && (!found_q || (prod < min_prod_q))) begin
            found_d    = 1'b1;
            min_prod_d = prod;
            best_c_d   = i_q;
            best_h_d   = j_q;
            best_p_d   = quot_m1;
          end
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((i_q == '1) && (j_q == '1)) begin
          upd_d = 1'b1;
          if (found_q) begin
            changed_d = (best_c_q != clk_sel_q) || (best_h_q != hs_sel_q);
            clk_sel_d = best_c_q;
            hs_sel_d  = best_h_q;
            period_d  = best_p_q;
          end else begin
            period_d = FALLBACK_PERIOD;
          end
          state_d = ST_DONE;
        end else begin
          {i_d, j_d} = {i_q, j_q} + 6'd1;
          state_d    = ST_TICK_GO;
        end
      end
      ST_FAST_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DEND_W'({tick_q, 5'b0_0000}) + DIV_DEND_W'(fv_q);
        div_req.divisor  = {fv_q, 1'b0};
        div_req.steps    = FAST_STEPS;
        state_d          = ST_FAST_WAIT;
      end
      ST_FAST_WAIT: begin
        if (div_rsp.done) begin
          period_d  = fast_period;
          running_d = 1'b1;
          upd_d     = 1'b1;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      clk_sel_q   <= '0;
      hs_sel_q    <= '0;
      period_q    <= RESET_PERIOD;
      running_q   <= 1'b0;
      src_q       <= SOURCE_CLOCK_RESET;
      mult_q      <= GRID_MULT_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clk_sel_q   <= clk_sel_d;
      hs_sel_q    <= hs_sel_d;
      period_q    <= period_d;
      running_q   <= running_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SOURCE_CLOCK: src_q  <= cfg_wdata_i;
          CFG_GRID_MULT:    mult_q <= cfg_wdata_i[MULT_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    f_q        <= f_d;
    fdes_q     <= fdes_d;
    fv_q       <= fv_d;
    tick_q     <= tick_d;
    i_q        <= i_d;
    j_q        <= j_d;
    found_q    <= found_d;
    min_prod_q <= min_prod_d;
    best_c_q   <= best_c_d;
    best_h_q   <= best_h_d;
    best_p_q   <= best_p_d;
    changed_q  <= changed_d;
    upd_q      <= upd_d;
    if (out_load) begin
      o_cdiv_q    <= clk_sel_q;
      o_hdiv_q    <= hs_sel_q;
      o_period_q  <= period_q;
      o_compare_q <= PERIOD_W'((17'(period_q) + 17'd1) >> 1);
      o_enabled_q <= running_q;
      o_changed_q <= changed_q;
      o_updated_q <= upd_q;
    end
  end

  assign in_i.ready              = (state_q == ST_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.clock_div_index   = o_cdiv_q;
  assign out_o.hs_div_index      = o_hdiv_q;
  assign out_o.period            = o_period_q;
  assign out_o.compare           = o_compare_q;
  assign out_o.output_enabled    = o_enabled_q;
  assign out_o.prescaler_changed = o_changed_q;
  assign out_o.updated           = o_updated_q;

endmodule

// ===== sv/pwmpp_checker.sv =====
// Port-level checks for the PWM planner, bound to the top level.
// Depends on pwmpp_pkg and on the port names of pwm_prescaler_period_planner_core.
module pwmpp_checker import pwmpp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SEL_W-1:0]    clock_div_index_i,
  input logic [SEL_W-1:0]    hs_div_index_i,
  input logic [PERIOD_W-1:0] period_i,
  input logic [PERIOD_W-1:0] compare_i,
  input logic                output_enabled_i,
  input logic                prescaler_changed_i,
  input logic                updated_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(period_i) && $stable(compare_i)
      && $stable(clock_div_index_i) && $stable(hs_div_index_i)
      && $stable(output_enabled_i) && $stable(prescaler_changed_i) && $stable(updated_i))
    else $error("Result changed while the receiver stalled.");

  a_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> compare_i == PERIOD_W'((17'(period_i) + 17'd1) >> 1))
    else $error("Compare value does not match half the period count.");

  a_changed_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prescaler_changed_i |-> updated_i)
    else $error("Divider change reported for an ignored command.");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("New transaction accepted while a command was in work.");

endmodule

bind pwm_prescaler_period_planner_core pwmpp_checker u_pwmpp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .clock_div_index_i   (out_o.clock_div_index),
  .hs_div_index_i      (out_o.hs_div_index),
  .period_i            (out_o.period),
  .compare_i           (out_o.compare),
  .output_enabled_i    (out_o.output_enabled),
  .prescaler_changed_i (out_o.prescaler_changed),
  .updated_i           (out_o.updated)
);

// ===== test/pwmpp_plan_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the PWM prescaler and period planner: it watches the command, result and
// register write traffic, predicts every result and compares it field by field.
// Depends on pwmpp_pkg, pwmpp_in_if and pwmpp_out_if.
module pwmpp_plan_checker import pwmpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pwmpp_in_if                  cmd_mon_i,
  pwmpp_out_if                 res_mon_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SRC_W-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef longint unsigned u64_t;

  localparam u64_t COUNTS_MIN = 2;
  localparam u64_t COUNTS_MAX = 65536;

  typedef struct packed {
    logic [SEL_W-1:0]    clk_idx;
    logic [SEL_W-1:0]    hs_idx;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] compare;
    logic                enabled;
    logic                changed;
    logic                updated;
  } plan_t;

  logic [SRC_W-1:0]    src_hz;
  logic [MULT_W-1:0]   grid_mult;
  logic [SEL_W-1:0]    clk_sel;
  logic [SEL_W-1:0]    hs_sel;
  logic [PERIOD_W-1:0] period_q;
  logic                running_q;
  plan_t               planned_q[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s is %0d, predicted %0d", name, got, want));
    end
  endtask

  function automatic u64_t hs_factor(input logic [SEL_W-1:0] sel);
    u64_t val;
    case (sel)
      3'd0:    val = 1;
      3'd1:    val = 2;
      3'd2:    val = 4;
      3'd3:    val = 6;
      3'd4:    val = 8;
      3'd5:    val = 10;
      3'd6:    val = 12;
      default: val = 14;
    endcase
    return val;
  endfunction

  function automatic u64_t divide_of(input logic [SEL_W-1:0] c, input logic [SEL_W-1:0] h);
    return (u64_t'(1) << c) * hs_factor(h);
  endfunction

  function automatic void run_search(input logic [FREQ_W-1:0] f16, output logic changed,
                                     output logic upd);
    u64_t fdes;
    u64_t tick;
    u64_t counts;
    u64_t divisor;
    u64_t min_divide;
    u64_t best_p;
    logic [SEL_W-1:0] best_c;
    logic [SEL_W-1:0] best_h;
    fdes = (u64_t'(f16) + 8) >> 4;
    changed = 1'b0;
    upd = 1'b0;
    best_c = clk_sel;
    best_h = hs_sel;
    best_p = u64_t'(FALLBACK_PERIOD);
    min_divide = 64'hFFFF_FFFF;
    if (fdes == 0) return;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        divisor = divide_of(i[SEL_W-1:0], j[SEL_W-1:0]);
        tick = u64_t'(src_hz) / divisor;
        if (tick != 0) begin
          counts = (tick + fdes / 2) / fdes;
          if (counts >= COUNTS_MIN && counts <= COUNTS_MAX && divisor < min_divide) begin
            min_divide = divisor;
            best_c = i[SEL_W-1:0];
            best_h = j[SEL_W-1:0];
            best_p = counts - 1;
          end
        end
      end
    end
    changed = (best_c != clk_sel) || (best_h != hs_sel);
    clk_sel = best_c;
    hs_sel = best_h;
    period_q = PERIOD_W'(best_p);
    upd = 1'b1;
  endfunction

  function automatic void run_fast(input u64_t f16, output logic upd);
    u64_t tick;
    u64_t counts;
    tick = u64_t'(src_hz) / divide_of(clk_sel, hs_sel);
    upd = 1'b0;
    if (tick == 0) return;
    upd = 1'b1;
    if (f16 == 0) begin
      running_q = 1'b0;
      return;
    end
    counts = (tick * 32 + f16) / (2 * f16);
    if (counts < COUNTS_MIN) counts = COUNTS_MIN;
    if (counts > COUNTS_MAX) counts = COUNTS_MAX;
    period_q = PERIOD_W'(counts - 1);
    running_q = 1'b1;
  endfunction

  function automatic plan_t plan_command(input logic [CMD_W-1:0] cmd,
                                         input logic [FREQ_W-1:0] f16);
    plan_t p;
    logic changed;
    logic upd;
    u64_t g;
    changed = 1'b0;
    upd = 1'b0;
    case (cmd)
      CMD_SEARCH: run_search(f16, changed, upd);
      CMD_FAST:   run_fast(u64_t'(f16), upd);
      CMD_GRID: begin
        g = u64_t'(f16);
        if (g < u64_t'(GRID_LOW)) g = u64_t'(GRID_LOW);
        if (g > u64_t'(GRID_HIGH)) g = u64_t'(GRID_HIGH);
        run_fast(g * u64_t'(grid_mult), upd);
      end
      default: ;
    endcase
    p.clk_idx = clk_sel;
    p.hs_idx = hs_sel;
    p.period = period_q;
    p.compare = PERIOD_W'((u64_t'(period_q) + 1) / 2);
    p.enabled = running_q;
    p.changed = changed;
    p.updated = upd;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plan_t want;
    if (!rst_ni) begin
      src_hz = SOURCE_CLOCK_RESET;
      grid_mult = GRID_MULT_RESET;
      clk_sel = '0;
      hs_sel = '0;
      period_q = RESET_PERIOD;
      running_q = 1'b0;
      planned_q.delete();
      pending_o = 0;
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (planned_q.size() == 0) begin
          report_error("result transaction with no command waiting for it");
        end else begin
          want = planned_q.pop_front();
          check_field("clock_div_index", res_mon_i.clock_div_index, want.clk_idx);
          check_field("hs_div_index", res_mon_i.hs_div_index, want.hs_idx);
          check_field("period", res_mon_i.period, want.period);
          check_field("compare", res_mon_i.compare, want.compare);
          check_field("output_enabled", res_mon_i.output_enabled, want.enabled);
          check_field("prescaler_changed", res_mon_i.prescaler_changed, want.changed);
          check_field("updated", res_mon_i.updated, want.updated);
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        planned_q.push_back(plan_command(cmd_mon_i.command, cmd_mon_i.freq_sixteenths));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SOURCE_CLOCK) src_hz = cfg_wdata_i;
        else if (cfg_index_i == CFG_GRID_MULT) grid_mult = cfg_wdata_i[MULT_W-1:0];
      end
      pending_o = planned_q.size();
    end
  end

endmodule

// ===== test/pwm_prescaler_period_planner_core_tb.sv =====
`timescale 1ns / 100ps
// Regression top for the PWM prescaler and period planner: clock, reset, register writes,
// command and result traffic with random idling, and the verdict.
// Depends on pwmpp_pkg, both channel interfaces, the planner core and pwmpp_plan_checker.
module pwm_prescaler_period_planner_core_tb;
  import pwmpp_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [FREQ_W-1:0] FREQ_MAX       = '1;
  localparam int                TIMEOUT_CYCLES = 3000000;
  localparam int                RX_HOLD_CYCLES = 6000;
  localparam int                DRAIN_CYCLES   = 100;
  localparam int                IDLE_PCT       = 24;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SRC_W-1:0]     cfg_wdata_i;
  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  int                   rx_hold_count;
  logic                 steady;
  logic                 rx_hold_req;
  logic                 rx_hold_done;

  pwmpp_in_if  cmd_if ();
  pwmpp_out_if res_if ();

  pwm_prescaler_period_planner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pwmpp_plan_checker plan_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon_i    (cmd_if),
    .res_mon_i    (res_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    res_if.ready = 1'b0;
    rx_hold_done = 1'b0;
    rx_hold_count = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        res_if.ready <= 1'b0;
        rx_hold_count++;
        rx_hold_done = (rx_hold_count >= RX_HOLD_CYCLES);
      end else if (steady) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FREQ_W-1:0] f16);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        cmd_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    cmd_if.valid <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.freq_sixteenths <= f16;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SRC_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [SRC_W-1:0] src, input logic [MULT_W-1:0] mult);
    drain();
    write_reg(CFG_SOURCE_CLOCK, src);
    write_reg(CFG_GRID_MULT, SRC_W'(mult));
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned span;
    if ($urandom_range(0, 9) < 3) return FREQ_W'($urandom);
    span = $urandom_range(0, FREQ_W - 1);
    return FREQ_W'(64'($urandom) & ((64'd2 << span) - 1));
  endfunction

  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      send_command(CMD_SEARCH, pick_freq());
    end else if (pick < 72) begin
      send_command(CMD_FAST, pick_freq());
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 1) send_command(CMD_GRID, FREQ_W'($urandom_range(0, 1500)));
      else send_command(CMD_GRID, pick_freq());
    end else begin
      send_command(CMD_UNUSED, pick_freq());
    end
  endtask

  task automatic run_phase(input logic [SRC_W-1:0] src, input logic [MULT_W-1:0] mult,
                           input int count, input logic hold);
    set_config(src, mult);
    if (hold) rx_hold_req = 1'b1;
    repeat (count) send_random();
  endtask

  task automatic run_directed();
    send_command(CMD_FAST, '0);
    send_command(CMD_SEARCH, '0);
    send_command(CMD_SEARCH, 30'd7);
    send_command(CMD_UNUSED, FREQ_MAX);
    send_command(CMD_SEARCH, 30'd32000);
    send_command(CMD_FAST, 30'd25600000);
    send_command(CMD_FAST, 30'd1);
    send_command(CMD_FAST, FREQ_MAX);
    send_command(CMD_SEARCH, 30'd24);
    send_command(CMD_SEARCH, 30'd24);
    send_command(CMD_SEARCH, FREQ_MAX);
    send_command(CMD_GRID, '0);
    send_command(CMD_GRID, FREQ_MAX);
    send_command(CMD_GRID, 30'd800);
    send_command(CMD_UNUSED, '0);
    send_command(CMD_FAST, 30'd160000);
    send_command(CMD_SEARCH, 30'd8);
    set_config(28'd1, 13'd0);
    send_command(CMD_FAST, 30'd1600);
    send_command(CMD_GRID, 30'd800);
    send_command(CMD_SEARCH, 30'd16);
    set_config(28'd200000000, 13'd0);
    send_command(CMD_GRID, 30'd800);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SOURCE_CLOCK;
    cfg_wdata_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_SEARCH;
    cmd_if.freq_sixteenths = '0;
    steady = 1'b0;
    rx_hold_req = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    run_directed();
    run_phase(28'd200000000, 13'd4096, 30, 1'b1);
    run_phase(28'd1, 13'd1, 14, 1'b0);
    run_phase(SRC_W'($urandom_range(1, 200000000)), MULT_W'($urandom_range(0, 8191)), 24, 1'b0);
    run_phase(SRC_W'($urandom_range(1000, 2000000)), MULT_W'($urandom_range(1, 4096)), 24, 1'b0);
    steady = 1'b1;
    run_phase(SOURCE_CLOCK_RESET, GRID_MULT_RESET, 24, 1'b0);
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pwmpp_pkg.sv
sv/pwmpp_in_if.sv
sv/pwmpp_out_if.sv
sv/pwmpp_div.sv
sv/pwm_prescaler_period_planner_core.sv
sv/pwmpp_checker.sv
test/pwmpp_plan_checker.sv
test/pwm_prescaler_period_planner_core_tb.sv
